// File: rtl/ddo_pkg.sv
// Shared constants and helper functions for the differential-drive odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int DIV_STEPS = 62;

  localparam logic [31:0] WHEEL_BASE_RESET = 32'd19661;

  localparam logic CMD_INTEGRATE = 1'b0;
  localparam logic CMD_SET_POSE = 1'b1;

  localparam logic REG_WHEEL_BASE = 1'b0;

  localparam logic signed [35:0] PI_Q29 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q29 = 36'sd3373259426;
  localparam logic [32:0] TWO_PI_U = 33'd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
  localparam logic signed [48:0] POS_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] POS_MIN = 49'sh1_8000_0000_0000;

  // Arctangent of 2^-i in Q2.30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd843314857;
      5'd1: v = 32'd497837829;
      5'd2: v = 32'd263043837;
      5'd3: v = 32'd133525159;
      5'd4: v = 32'd67021687;
      5'd5: v = 32'd33543516;
      5'd6: v = 32'd16775851;
      5'd7: v = 32'd8388437;
      5'd8: v = 32'd4194283;
      5'd9: v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Brings an angle within three half turns of zero into (-pi, pi].
  function automatic logic signed [31:0] wrap_once(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v;
    if (v > PI_Q29) begin
      t = v - TWO_PI_Q29;
    end else if (v <= -PI_Q29) begin
      t = v + TWO_PI_Q29;
    end
    return $signed(t[31:0]);
  endfunction

endpackage

// File: rtl/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a Q3.29 angle in Q2.30.
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic {CS_IDLE, CS_RUN} cs_state_t;

  cs_state_t         state_r;
  logic [IW-1:0]     i_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic              neg_r;
  logic              done_r;
  logic signed [33:0] cos_r, sin_r;

  logic signed [33:0] z_in, z_pre;
  logic               neg_pre;
  logic signed [33:0] xs, ys, at, x_n, y_n, z_n;

  always_comb begin
    z_in = $signed({angle_i[31], angle_i, 1'b0});
    z_pre = z_in;
    neg_pre = 1'b0;
    if (z_in > ddo_pkg::HALF_PI_Q30) begin
      z_pre = z_in - ddo_pkg::PI_Q30;
      neg_pre = 1'b1;
    end else if (z_in < -ddo_pkg::HALF_PI_Q30) begin
      z_pre = z_in + ddo_pkg::PI_Q30;
      neg_pre = 1'b1;
    end
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({2'b00, ddo_pkg::atan_q30(5'(i_r))});
    if (!z_r[33]) begin
      x_n = x_r - ys;
      y_n = y_r + xs;
      z_n = z_r - at;
    end else begin
      x_n = x_r + ys;
      y_n = y_r - xs;
      z_n = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        CS_IDLE: begin
          if (start_i) begin
            x_r <= ddo_pkg::CORDIC_GAIN_Q30;
            y_r <= '0;
            z_r <= z_pre;
            neg_r <= neg_pre;
            i_r <= '0;
            state_r <= CS_RUN;
          end
        end
        CS_RUN: begin
          x_r <= x_n;
          y_r <= y_n;
          z_r <= z_n;
          i_r <= i_r + 1'b1;
          if (i_r == IW'(CORDIC_STEPS - 1)) begin
            cos_r <= neg_r ? -x_n : x_n;
            sin_r <= neg_r ? -y_n : y_n;
            done_r <= 1'b1;
            state_r <= CS_IDLE;
          end
        end
        default: state_r <= CS_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer, divider, multiplier and pose.
// A set-pose request skips the divider, CORDIC and multiplier. An integrate request runs the
// bit-serial divider, which forms the heading change one quotient bit per cycle while reducing
// it modulo 2pi, followed by the iterative CORDIC and four passes through one 32 by 18 bit
// multiplier. The block accepts no request while one is in work, but takes the next one while
// a finished pose still waits in the output register. The wheel base is written through the
// APB port at byte address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // left_distance, right_distance, new_x, new_y, new_theta
  input  logic [191:0]  in_tdata,
  // cmd
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // pos_x, pos_y, heading
  output logic [127:0]  out_tdata,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ANG, ST_ROT, ST_MUL, ST_POS, ST_DONE
  } state_t;

  state_t              state_r;
  logic [31:0]         wb_r;
  logic signed [47:0]  pos_x_r, pos_y_r;
  logic signed [31:0]  theta_r;
  logic signed [31:0]  ds_r;
  logic                neg_r;
  logic [32:0]         num_r;
  logic [31:0]         div_rem_r;
  logic [31:0]         rq_r, rh_r;
  logic                qlast_r;
  logic [5:0]          cnt_r;
  logic signed [31:0]  mid_r, th_new_r;
  logic                cor_start_r;
  logic [2:0]          mcnt_r;
  logic signed [49:0]  prod_r;
  logic signed [65:0]  acc_x_r, acc_y_r;
  logic signed [47:0]  nx_r, ny_r;
  logic                out_valid_r;
  logic [127:0]        out_data_r;

  logic                cor_done;
  logic signed [33:0]  cor_cos, cor_sin;

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cor_start_r),
    .angle_i (mid_r),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  logic               cfg_wr;
  logic               accept;
  logic signed [32:0] l_in, r_in, sum_lr, diff_lr;
  logic [32:0]        mag;
  logic [32:0]        rem_s, rem_n, qt_s, qt_n;
  logic               qbit;
  logic [32:0]        mh_s, mh;
  logic signed [33:0] dfull, dhalf;
  logic signed [31:0] th_full, th_mid, th_set;
  logic [17:0]        opnd;
  logic signed [49:0] prod_w;
  logic signed [65:0] prod_ext;
  logic signed [35:0] rx, ry;
  logic signed [48:0] sx, sy;
  logic signed [47:0] sat_x, sat_y;
  logic               out_free;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ddo_pkg::REG_WHEEL_BASE) ? wb_r : 32'd0;

  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    l_in = $signed({in_tdata[31], in_tdata[31:0]});
    r_in = $signed({in_tdata[63], in_tdata[63:32]});
    sum_lr = l_in + r_in;
    diff_lr = r_in - l_in;
    mag = diff_lr[32] ? 33'(-diff_lr) : 33'(diff_lr);
    th_set = ddo_pkg::wrap_once($signed({{4{in_tdata[191]}}, in_tdata[191:160]}));

    rem_s = {div_rem_r, num_r[32]};
    qbit = (wb_r != 32'd0) && (rem_s >= {1'b0, wb_r});
    rem_n = qbit ? rem_s - {1'b0, wb_r} : rem_s;
    qt_s = {rq_r, qbit};
    qt_n = (qt_s >= ddo_pkg::TWO_PI_U) ? qt_s - ddo_pkg::TWO_PI_U : qt_s;

    mh_s = {1'b0, rh_r} + {32'd0, neg_r & qlast_r};
    mh = (mh_s >= ddo_pkg::TWO_PI_U) ? mh_s - ddo_pkg::TWO_PI_U : mh_s;
    dfull = neg_r ? -$signed({2'b00, rq_r}) : $signed({2'b00, rq_r});
    dhalf = neg_r ? -$signed({1'b0, mh}) : $signed({1'b0, mh});
    th_full = ddo_pkg::wrap_once($signed({{4{theta_r[31]}}, theta_r})
                                 + $signed({{2{dfull[33]}}, dfull}));
    th_mid = ddo_pkg::wrap_once($signed({{4{theta_r[31]}}, theta_r})
                                + $signed({{2{dhalf[33]}}, dhalf}));

    case (mcnt_r)
      3'd0: opnd = {1'b0, cor_cos[16:0]};
      3'd1: opnd = {cor_cos[33], cor_cos[33:17]};
      3'd2: opnd = {1'b0, cor_sin[16:0]};
      3'd3: opnd = {cor_sin[33], cor_sin[33:17]};
      default: opnd = 18'd0;
    endcase
    prod_w = ds_r * $signed(opnd);
    prod_ext = $signed({{16{prod_r[49]}}, prod_r});

    rx = $signed(36'((acc_x_r + ddo_pkg::ROUND_HALF) >>> 30));
    ry = $signed(36'((acc_y_r + ddo_pkg::ROUND_HALF) >>> 30));
    sx = $signed({pos_x_r[47], pos_x_r}) + $signed({{13{rx[35]}}, rx});
    sy = $signed({pos_y_r[47], pos_y_r}) + $signed({{13{ry[35]}}, ry});
    sat_x = (sx > ddo_pkg::POS_MAX) ? ddo_pkg::POS_MAX[47:0] :
            (sx < ddo_pkg::POS_MIN) ? ddo_pkg::POS_MIN[47:0] : sx[47:0];
    sat_y = (sy > ddo_pkg::POS_MAX) ? ddo_pkg::POS_MAX[47:0] :
            (sy < ddo_pkg::POS_MIN) ? ddo_pkg::POS_MIN[47:0] : sy[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wb_r <= ddo_pkg::WHEEL_BASE_RESET;
      pos_x_r <= '0;
      pos_y_r <= '0;
      theta_r <= '0;
      cor_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cor_start_r <= 1'b0;
      if (cfg_wr && cfg_paddr[2] == ddo_pkg::REG_WHEEL_BASE) begin
        wb_r <= cfg_pwdata;
      end
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_tuser == ddo_pkg::CMD_SET_POSE) begin
              nx_r <= $signed(in_tdata[111:64]);
              ny_r <= $signed(in_tdata[159:112]);
              th_new_r <= th_set;
              state_r <= ST_DONE;
            end else begin
              ds_r <= sum_lr[32:1];
              neg_r <= diff_lr[32];
              num_r <= mag;
              div_rem_r <= '0;
              rq_r <= '0;
              rh_r <= '0;
              qlast_r <= 1'b0;
              cnt_r <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          num_r <= {num_r[31:0], 1'b0};
          div_rem_r <= rem_n[31:0];
          rh_r <= rq_r;
          rq_r <= qt_n[31:0];
          qlast_r <= qbit;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'(ddo_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_ANG;
          end
        end
        ST_ANG: begin
          th_new_r <= th_full;
          mid_r <= th_mid;
          cor_start_r <= 1'b1;
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          mcnt_r <= '0;
          if (cor_done) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= prod_w;
          mcnt_r <= mcnt_r + 1'b1;
          case (mcnt_r)
            3'd1: acc_x_r <= prod_ext;
            3'd2: acc_x_r <= acc_x_r + (prod_ext <<< 17);
            3'd3: acc_y_r <= prod_ext;
            3'd4: begin
              acc_y_r <= acc_y_r + (prod_ext <<< 17);
              state_r <= ST_POS;
            end
            default: ;
          endcase
        end
        ST_POS: begin
          nx_r <= sat_x;
          ny_r <= sat_y;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            pos_x_r <= nx_r;
            pos_y_r <= ny_r;
            theta_r <= th_new_r;
            out_data_r <= {th_new_r, ny_r, nx_r};
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a request was in work");

  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({{4{theta_r[31]}}, theta_r}) > -ddo_pkg::PI_Q29 &&
    $signed({{4{theta_r[31]}}, theta_r}) <= ddo_pkg::PI_Q29)
    else $error("stored heading left (-pi, pi]");

  a_out_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $signed({{4{out_data_r[127]}}, out_data_r[127:96]}) > -ddo_pkg::PI_Q29 &&
    $signed({{4{out_data_r[127]}}, out_data_r[127:96]}) <= ddo_pkg::PI_Q29)
    else $error("reported heading left (-pi, pi]");

  a_mod_residue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> {1'b0, rq_r} < ddo_pkg::TWO_PI_U && {1'b0, rh_r} < ddo_pkg::TWO_PI_U)
    else $error("heading residue not reduced below 2pi");

endmodule
